>>> sv/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mste_pkg.sv
// shared constants, codes and types of the matrix stack transform engine
package mste_pkg;

  localparam int unsigned DATA_W          = 48;
  localparam int unsigned HALF_W          = 24;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned ELEM_W          = 4;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_XFORM = 2'd3
  } mste_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ZERO_W = 2'd3
  } mste_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_READ,
    ST_MAC,
    ST_WAIT,
    ST_DIV,
    ST_RESP
  } mste_state_e;

  typedef struct packed {
    logic start;
    logic clear;
  } mste_unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mste_unit_stat_t;

endpackage

>>> sv/mste_ifs.sv
// command and result channel interfaces
interface mste_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic [mste_pkg::ELEM_W-1:0]          elem_index;
  logic signed [mste_pkg::DATA_W-1:0]   elem_value;
  logic signed [mste_pkg::DATA_W-1:0]   vert_x;
  logic signed [mste_pkg::DATA_W-1:0]   vert_y;
  logic signed [mste_pkg::DATA_W-1:0]   vert_z;

  modport source (
    output valid, cmd, elem_index, elem_value, vert_x, vert_y, vert_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, elem_index, elem_value, vert_x, vert_y, vert_z,
    output ready
  );
endinterface

interface mste_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [mste_pkg::DATA_W-1:0]   out_x;
  logic signed [mste_pkg::DATA_W-1:0]   out_y;
  logic signed [mste_pkg::DATA_W-1:0]   out_z;
  logic [mste_pkg::CNT_W-1:0]           stack_count;

  modport source (
    output valid, status, out_x, out_y, out_z, stack_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_x, out_y, out_z, stack_count,
    output ready
  );
endinterface

>>> sv/mste_ram.sv
// generic single write port, single read port ram with registered read
module mste_ram #(
  parameter int unsigned WIDTH = mste_pkg::DATA_W,
  parameter int unsigned DEPTH = mste_pkg::STACK_DEPTH_DEF * 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mste_mac.sv
// shared multiply-accumulate unit: 48x48 product in four 25x25 partials, then round and saturate
`include "assert_macros.svh"

module mste_mac #(
  parameter int unsigned FRAC_BITS = mste_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mste_pkg::mste_unit_ctrl_t          ctrl_i,
  input  logic signed [mste_pkg::DATA_W-1:0] a_i,
  input  logic signed [mste_pkg::DATA_W-1:0] b_i,
  output mste_pkg::mste_unit_stat_t          stat_o,
  output logic signed [mste_pkg::DATA_W-1:0] result_o
);

  localparam int unsigned DW    = mste_pkg::DATA_W;
  localparam int unsigned HW    = mste_pkg::HALF_W;
  localparam int unsigned PW    = 2 * (HW + 1);
  localparam int unsigned ACC_W = 2 * DW + 2;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN  = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0]    MAX_DW   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]    MIN_DW   = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0]    a_q, b_q;
  logic [1:0]              step_q, sh_q;
  logic                    mul_act_q, add_act_q, add_last_q, rnd_act_q, done_q;
  logic signed [PW-1:0]    prod_q, prod_d;
  logic signed [HW:0]      da, db;
  logic signed [ACC_W-1:0] acc_q, prod_ext, term, sum_rnd, shifted;
  logic signed [DW-1:0]    rnd_q, sat;

  // low digits unsigned, high digits signed
  always_comb begin
    da       = step_q[1] ? {a_q[DW-1], a_q[DW-1:HW]} : {1'b0, a_q[HW-1:0]};
    db       = step_q[0] ? {b_q[DW-1], b_q[DW-1:HW]} : {1'b0, b_q[HW-1:0]};
    prod_d   = da * db;
    prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};
    case (sh_q)
      2'd0:    term = prod_ext;
      2'd3:    term = prod_ext <<< (2 * HW);
      default: term = prod_ext <<< HW;
    endcase
    sum_rnd = acc_q + HALF_LSB;
    shifted = sum_rnd >>> FRAC_BITS;
    if (shifted > SAT_MAX) begin
      sat = MAX_DW;
    end else if (shifted < SAT_MIN) begin
      sat = MIN_DW;
    end else begin
      sat = shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      mul_act_q  <= 1'b0;
      add_act_q  <= 1'b0;
      add_last_q <= 1'b0;
      rnd_act_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (ctrl_i.start) begin
        mul_act_q <= 1'b1;
        step_q    <= '0;
      end else if (mul_act_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          mul_act_q <= 1'b0;
        end
      end
      add_act_q  <= mul_act_q;
      add_last_q <= mul_act_q && (step_q == 2'd3);
      rnd_act_q  <= add_act_q && add_last_q;
      done_q     <= rnd_act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (mul_act_q) begin
      prod_q <= prod_d;
      sh_q   <= step_q;
    end
    if (ctrl_i.start && ctrl_i.clear) begin
      acc_q <= '0;
    end else if (add_act_q) begin
      acc_q <= acc_q + term;
    end
    if (rnd_act_q) begin
      rnd_q <= sat;
    end
  end

  assign stat_o.busy = mul_act_q | add_act_q | rnd_act_q;
  assign stat_o.done = done_q;
  assign result_o    = rnd_q;

  `ASSERT_IMPL(a_mac_start_idle, ctrl_i.start, !stat_o.busy, "mac started while busy")

endmodule

>>> sv/mste_div.sv
// radix-2 restoring divider: (num << FRAC_BITS) / den, truncated and saturated
`include "assert_macros.svh"

module mste_div #(
  parameter int unsigned FRAC_BITS = mste_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mste_pkg::DATA_W-1:0] num_i,
  input  logic signed [mste_pkg::DATA_W-1:0] den_i,
  output mste_pkg::mste_unit_stat_t          stat_o,
  output logic signed [mste_pkg::DATA_W-1:0] quo_o
);

  localparam int unsigned DW = mste_pkg::DATA_W;
  localparam int unsigned NW = DW + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  localparam logic signed [DW-1:0] MAX_DW = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_DW = {1'b1, {(DW-1){1'b0}}};

  logic          run_q, fin_q, done_q, neg_q, ge;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] sh_q;
  logic [DW-1:0] rem_q, d_q, rem_next, num_mag, den_mag;
  logic [DW:0]   trial;
  logic          pos_ovf, neg_ovf;
  logic signed [DW-1:0] quo_q, sat;

  always_comb begin
    num_mag  = num_i[DW-1] ? (~num_i + 1'b1) : num_i;
    den_mag  = den_i[DW-1] ? (~den_i + 1'b1) : den_i;
    trial    = {rem_q, sh_q[NW-1]};
    ge       = trial >= {1'b0, d_q};
    rem_next = ge ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
    pos_ovf  = |sh_q[NW-1:DW-1];
    neg_ovf  = (|sh_q[NW-1:DW]) || (sh_q[DW-1] && (|sh_q[DW-2:0]));
    if (neg_q) begin
      sat = neg_ovf ? MIN_DW : (~sh_q[DW-1:0] + 1'b1);
    end else begin
      sat = pos_ovf ? MAX_DW : sh_q[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
        end
      end
      fin_q  <= run_q && (cnt_q == CW'(1));
      done_q <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      d_q   <= den_mag;
      neg_q <= num_i[DW-1] ^ den_i[DW-1];
    end else if (run_q) begin
      sh_q  <= {sh_q[NW-2:0], ge};
      rem_q <= rem_next;
    end
    if (fin_q) begin
      quo_q <= sat;
    end
  end

  assign stat_o.busy = run_q | fin_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  `ASSERT_IMPL(a_div_start_idle, start_i, !stat_o.busy, "divider started while busy")

endmodule

>>> sv/matrix_stack_transform_engine.sv
// top level of the matrix stack transform engine: sequencer, stack memory and staging matrix
//
// A stack of 4x4 signed fixed point matrices (FRAC_BITS fraction bits, 48-bit
// elements) with one command channel and one result channel; every accepted
// command beat yields exactly one result beat. Load writes one staging element,
// push copies the staging matrix onto an empty stack or stores top x staging
// as the new top, pop drops the top, transform multiplies (x, y, z, 1) by the
// top matrix and divides x, y, z by w. The block takes one command at a time;
// cmd ready is high only while the sequencer is idle, and the result register
// lets the next command in while a result waits to be taken. A push onto an
// empty stack copies one staging element per cycle; a push onto a non-empty
// stack runs each of its 16 x 4 terms through the shared multiply-accumulate
// unit, which takes each term through stack memory read, the four partial
// products of the 48x48 term, accumulate and rounding; a transform runs its
// 4 x 4 terms the same way, and each of its three divides runs one quotient
// bit a cycle in the shared restoring divider. Products and row sums are exact,
// then rounded half up and saturated to 48 bits; the quotient truncates toward
// zero and saturates. Status reports stack full, stack empty and zero w, and
// stack_count carries the low five bits of the stack level after the command.
// The stack memory needs no clearing: only levels written by a push are read.
`include "assert_macros.svh"

module matrix_stack_transform_engine #(
  parameter int unsigned STACK_DEPTH = mste_pkg::STACK_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = mste_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mste_cmd_if.sink   cmd_i,
  mste_res_if.source res_o
);

  localparam int unsigned DW     = mste_pkg::DATA_W;
  localparam int unsigned EW     = mste_pkg::ELEM_W;
  localparam int unsigned CNT_W  = mste_pkg::CNT_W;
  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(STACK_DEPTH);
  localparam int unsigned ADDR_W = IDX_W + EW;
  localparam int unsigned MEM_D  = STACK_DEPTH * 16;

  // fixed point 1.0 for the implicit w coordinate of the vertex
  localparam logic signed [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

  mste_pkg::mste_state_e  state_q, state_d;
  mste_pkg::mste_status_e status_q, status_d, ostat_q, ostat_d;

  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [EW-1:0]        elem_q, elem_d;   // row in [3:2], column in [1:0]
  logic [1:0]           k_q, k_d;         // term index of the dot product
  logic                 xform_q, xform_d;
  logic signed [DW-1:0] w_q, w_d;
  logic signed [DW-1:0] vx_q, vy_q, vz_q;
  logic signed [DW-1:0] rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic signed [DW-1:0] staging_q [16];

  logic                 ovalid_q, ovalid_d;
  logic signed [DW-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [CNT_W-1:0]     ocnt_q, ocnt_d;

  logic                 in_acc, out_acc, stg_we;
  logic [IDX_W-1:0]     top_idx, dst_idx;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;

  mste_pkg::mste_unit_ctrl_t mac_ctrl;
  mste_pkg::mste_unit_stat_t mac_stat, div_stat;
  logic signed [DW-1:0] mac_b, mac_res, div_quo, vk;
  logic                 div_start;

  assign cmd_i.ready = (state_q == mste_pkg::ST_IDLE);
  assign in_acc      = cmd_i.valid && cmd_i.ready;
  assign out_acc     = res_o.valid && res_o.ready;

  // top of stack is level-1, a push writes level
  assign top_idx = IDX_W'(lvl_q - 1'b1);
  assign dst_idx = IDX_W'(lvl_q);

  // second operand: vertex coordinate for transforms, staging column for pushes
  always_comb begin
    case (k_q)
      2'd0:    vk = vx_q;
      2'd1:    vk = vy_q;
      2'd2:    vk = vz_q;
      default: vk = ONE_FX;
    endcase
    mac_b = xform_q ? vk : staging_q[{k_q, elem_q[1:0]}];
  end

  // stack memory, one 16-element matrix per level
  mste_ram #(
    .WIDTH (DW),
    .DEPTH (MEM_D)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared multiply-accumulate, first operand always straight from memory
  mste_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (ram_rdata),
    .b_i      (mac_b),
    .stat_o   (mac_stat),
    .result_o (mac_res)
  );

  // divide of a rounded row sum by w
  mste_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mac_res),
    .den_i   (w_q),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    lvl_d     = lvl_q;
    elem_d    = elem_q;
    k_d       = k_q;
    xform_d   = xform_q;
    w_d       = w_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    rz_d      = rz_q;
    ovalid_d  = ovalid_q && !out_acc;
    ostat_d   = ostat_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oz_d      = oz_q;
    ocnt_d    = ocnt_q;
    ram_we    = 1'b0;
    ram_waddr = {dst_idx, elem_q};
    ram_wdata = mac_res;
    ram_raddr = {top_idx, elem_q[3:2], k_q};
    mac_ctrl  = '0;
    div_start = 1'b0;
    stg_we    = 1'b0;

    unique case (state_q)
      mste_pkg::ST_IDLE: begin
        if (in_acc) begin
          rx_d     = '0;
          ry_d     = '0;
          rz_d     = '0;
          k_d      = '0;
          elem_d   = '0;
          status_d = mste_pkg::STAT_OK;
          state_d  = mste_pkg::ST_RESP;
          unique case (cmd_i.cmd)
            mste_pkg::CMD_LOAD: begin
              stg_we = 1'b1;
            end
            mste_pkg::CMD_PUSH: begin
              if (lvl_q == LVL_W'(STACK_DEPTH)) begin
                status_d = mste_pkg::STAT_FULL;
              end else if (lvl_q == '0) begin
                state_d = mste_pkg::ST_COPY;
              end else begin
                xform_d = 1'b0;
                state_d = mste_pkg::ST_READ;
              end
            end
            mste_pkg::CMD_POP: begin
              if (lvl_q == '0) begin
                status_d = mste_pkg::STAT_EMPTY;
              end else begin
                lvl_d = lvl_q - 1'b1;
              end
            end
            mste_pkg::CMD_XFORM: begin
              if (lvl_q == '0) begin
                status_d = mste_pkg::STAT_EMPTY;
              end else begin
                // w row first, it gates the divides
                xform_d = 1'b1;
                elem_d  = {2'd3, 2'd0};
                state_d = mste_pkg::ST_READ;
              end
            end
          endcase
        end
      end

      mste_pkg::ST_COPY: begin
        ram_we    = 1'b1;
        ram_waddr = {IDX_W'(0), elem_q};
        ram_wdata = staging_q[elem_q];
        elem_d    = elem_q + 1'b1;
        if (elem_q == '1) begin
          lvl_d   = LVL_W'(1);
          state_d = mste_pkg::ST_RESP;
        end
      end

      mste_pkg::ST_READ: begin
        // memory address issued here, data valid next cycle
        state_d = mste_pkg::ST_MAC;
      end

      mste_pkg::ST_MAC: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.clear = (k_q == 2'd0);
        state_d        = mste_pkg::ST_WAIT;
      end

      mste_pkg::ST_WAIT: begin
        if (mac_stat.done) begin
          if (k_q != 2'd3) begin
            k_d     = k_q + 2'd1;
            state_d = mste_pkg::ST_READ;
          end else begin
            k_d = '0;
            if (!xform_q) begin
              // product element goes straight to the new level
              ram_we = 1'b1;
              if (elem_q == '1) begin
                lvl_d   = lvl_q + 1'b1;
                state_d = mste_pkg::ST_RESP;
              end else begin
                elem_d  = elem_q + 1'b1;
                state_d = mste_pkg::ST_READ;
              end
            end else if (elem_q[3:2] == 2'd3) begin
              w_d = mac_res;
              if (mac_res == '0) begin
                status_d = mste_pkg::STAT_ZERO_W;
                state_d  = mste_pkg::ST_RESP;
              end else begin
                elem_d  = '0;
                state_d = mste_pkg::ST_READ;
              end
            end else begin
              div_start = 1'b1;
              state_d   = mste_pkg::ST_DIV;
            end
          end
        end
      end

      mste_pkg::ST_DIV: begin
        if (div_stat.done) begin
          case (elem_q[3:2])
            2'd0:    rx_d = div_quo;
            2'd1:    ry_d = div_quo;
            default: rz_d = div_quo;
          endcase
          if (elem_q[3:2] == 2'd2) begin
            state_d = mste_pkg::ST_RESP;
          end else begin
            elem_d  = elem_q + EW'(4);
            state_d = mste_pkg::ST_READ;
          end
        end
      end

      mste_pkg::ST_RESP: begin
        // result register frees up when empty or taken this cycle
        if (!ovalid_q || res_o.ready) begin
          ovalid_d = 1'b1;
          ostat_d  = status_q;
          ox_d     = rx_q;
          oy_d     = ry_q;
          oz_d     = rz_q;
          ocnt_d   = CNT_W'(lvl_q);
          state_d  = mste_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mste_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mste_pkg::ST_IDLE;
      lvl_q    <= '0;
      elem_q   <= '0;
      k_q      <= '0;
      xform_q  <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        staging_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      lvl_q    <= lvl_d;
      elem_q   <= elem_d;
      k_q      <= k_d;
      xform_q  <= xform_d;
      ovalid_q <= ovalid_d;
      if (stg_we) begin
        staging_q[cmd_i.elem_index] <= cmd_i.elem_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vx_q <= cmd_i.vert_x;
      vy_q <= cmd_i.vert_y;
      vz_q <= cmd_i.vert_z;
    end
    status_q <= status_d;
    w_q      <= w_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rz_q     <= rz_d;
    ostat_q  <= ostat_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oz_q     <= oz_d;
    ocnt_q   <= ocnt_d;
  end

  assign res_o.valid       = ovalid_q;
  assign res_o.status      = ostat_q;
  assign res_o.out_x       = ox_q;
  assign res_o.out_y       = oy_q;
  assign res_o.out_z       = oz_q;
  assign res_o.stack_count = ocnt_q;

  `ASSERT_IMPL(a_lvl_bound, 1'b1, lvl_q <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
  `ASSERT_IMPL(a_lvl_step, lvl_q != $past(lvl_q), (lvl_q == LVL_W'($past(lvl_q) + 1'b1)) || (lvl_q == LVL_W'($past(lvl_q) - 1'b1)), "stack level jumped")
  `ASSERT_IMPL(a_idle_units, state_q == mste_pkg::ST_IDLE, !mac_stat.busy && !div_stat.busy, "unit busy while idle")
  `ASSERT_NEXT(a_full_push, in_acc && (cmd_i.cmd == mste_pkg::CMD_PUSH) && (lvl_q == LVL_W'(STACK_DEPTH)), (status_q == mste_pkg::STAT_FULL) && (state_q == mste_pkg::ST_RESP), "full push not rejected")

endmodule

>>> test/mste_result_checker.sv
`timescale 1ns / 100ps
// result checker for the matrix stack transform engine: predicts every result beat and compares it
module mste_result_checker
  import mste_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mste_cmd_if         cmd_i,
  mste_res_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [127:0]      wide_t;

  typedef struct packed {
    mste_status_e         status;
    logic [DATA_W-1:0]    x, y, z;
    logic [CNT_W-1:0]     count;
  } result_t;

  localparam wide_t FIX_MAX = (wide_t'(1) <<< (DATA_W - 1)) - wide_t'(1);
  localparam wide_t FIX_MIN = -(wide_t'(1) <<< (DATA_W - 1));

  fix_t        staging_q [16];
  fix_t        store_q   [STACK_DEPTH][16];
  int unsigned level_q;
  result_t     due_results [$];
  result_t     oldest;
  int unsigned errors;

  function automatic wide_t mul(fix_t a, fix_t b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // round half up to FRAC_BITS fraction bits, then clamp to 48 bits
  function automatic fix_t round_sat(wide_t acc);
    wide_t t;
    t = (acc + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > FIX_MAX) t = FIX_MAX;
    else if (t < FIX_MIN) t = FIX_MIN;
    return fix_t'(t);
  endfunction

  // quotient truncates toward zero
  function automatic fix_t div_sat(fix_t num, fix_t den);
    wide_t n;
    wide_t d;
    wide_t q;
    n = num;
    d = den;
    q = (n <<< FRAC_BITS) / d;
    if (q > FIX_MAX) q = FIX_MAX;
    else if (q < FIX_MIN) q = FIX_MIN;
    return fix_t'(q);
  endfunction

  function automatic fix_t row_dot(int unsigned lvl, int unsigned row, fix_t v [4]);
    wide_t acc;
    acc = '0;
    for (int k = 0; k < 4; k++) acc += mul(store_q[lvl][row*4+k], v[k]);
    return round_sat(acc);
  endfunction

  function automatic result_t apply_command(mste_cmd_e op, logic [ELEM_W-1:0] idx, fix_t val,
                                            fix_t x, fix_t y, fix_t z);
    result_t r;
    fix_t    v [4];
    fix_t    w;
    wide_t   acc;
    r = '0;
    r.status = STAT_OK;
    case (op)
      CMD_LOAD: staging_q[idx] = val;
      CMD_PUSH: begin
        if (level_q >= STACK_DEPTH) begin
          r.status = STAT_FULL;
        end else if (level_q == 0) begin
          store_q[0] = staging_q;
          level_q = 1;
        end else begin
          for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
              acc = '0;
              for (int k = 0; k < 4; k++)
                acc += mul(store_q[level_q-1][row*4+k], staging_q[k*4+col]);
              store_q[level_q][row*4+col] = round_sat(acc);
            end
          end
          level_q++;
        end
      end
      CMD_POP: begin
        if (level_q == 0) r.status = STAT_EMPTY;
        else level_q--;
      end
      default: begin
        if (level_q == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          v[0] = x;
          v[1] = y;
          v[2] = z;
          v[3] = fix_t'(1) <<< FRAC_BITS;
          w = row_dot(level_q - 1, 3, v);
          if (w == '0) begin
            r.status = STAT_ZERO_W;
          end else begin
            r.x = div_sat(row_dot(level_q - 1, 0, v), w);
            r.y = div_sat(row_dot(level_q - 1, 1, v), w);
            r.z = div_sat(row_dot(level_q - 1, 2, v), w);
          end
        end
      end
    endcase
    r.count = level_q[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string field, logic signed [63:0] want, logic signed [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (staging_q[i]) staging_q[i] = '0;
      level_q = 0;
      due_results.delete();
      errors = 0;
      pending_o <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      // retire first: a command's own result never leaves on its accept edge
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing outstanding, expected none, got status %0d",
                   $time, res_i.status);
        end else begin
          oldest = due_results.pop_front();
          if (res_i.status !== oldest.status)
            note_mismatch("status", oldest.status, res_i.status);
          if (res_i.out_x !== oldest.x)
            note_mismatch("out_x", $signed(oldest.x), res_i.out_x);
          if (res_i.out_y !== oldest.y)
            note_mismatch("out_y", $signed(oldest.y), res_i.out_y);
          if (res_i.out_z !== oldest.z)
            note_mismatch("out_z", $signed(oldest.z), res_i.out_z);
          if (res_i.stack_count !== oldest.count)
            note_mismatch("stack_count", oldest.count, res_i.stack_count);
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        due_results.push_back(apply_command(mste_cmd_e'(cmd_i.cmd), cmd_i.elem_index,
                                            cmd_i.elem_value, cmd_i.vert_x, cmd_i.vert_y,
                                            cmd_i.vert_z));
      pending_o <= due_results.size();
      mismatch_cnt_o <= errors;
    end
  end

endmodule

>>> test/tb_matrix_stack_transform_engine.sv
`timescale 1ns / 100ps
// testbench top for the matrix stack transform engine: command stimulus, result drain and verdict
module tb_matrix_stack_transform_engine;
  import mste_pkg::*;

  localparam int unsigned ITEMS        = 550;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned DRAIN_CYCLES = 16;

  // handy fixed point constants, 48 bits with FRAC_BITS_DEF fraction bits
  localparam logic [DATA_W-1:0] FIX_ONE  = 48'(1) << FRAC_BITS_DEF;
  localparam logic [DATA_W-1:0] FIX_HALF = FIX_ONE >> 1;
  localparam logic [DATA_W-1:0] FIX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] FIX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mste_cmd_if cmd_if ();
  mste_res_if res_if ();

  int unsigned mismatches;
  int unsigned pending;

  // sender bookkeeping: beats sent, beats left in the current burst, and a
  // rough mirror of the stack level used only to steer the random scenarios
  int unsigned sent;
  int unsigned burst_left;
  int unsigned stack_est;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  matrix_stack_transform_engine #(
    .STACK_DEPTH (STACK_DEPTH_DEF),
    .FRAC_BITS   (FRAC_BITS_DEF)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  mste_result_checker #(
    .STACK_DEPTH (STACK_DEPTH_DEF),
    .FRAC_BITS   (FRAC_BITS_DEF)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // any 48-bit pattern
  function automatic logic [DATA_W-1:0] rnd48();
    return {$urandom, $urandom};
  endfunction

  // operand mix: mostly values near unit scale so transforms stay meaningful,
  // plus tiny values, raw patterns and the two extremes
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      s = int'($urandom_range(0, 8 << FRAC_BITS_DEF)) - (4 << FRAC_BITS_DEF);
      return 48'(s);
    end else if (r < 65) begin
      s = int'($urandom_range(0, 600)) - 300;
      return 48'(s);
    end else if (r < 80) begin
      return rnd48();
    end else if (r < 87) begin
      return FIX_MAX;
    end else if (r < 94) begin
      return FIX_MIN;
    end else if (r < 97) begin
      return '0;
    end
    return FIX_ONE;
  endfunction

  // present one command beat and hold it until the engine takes it; bursts
  // of back-to-back beats alternate with idle gaps, now and then long ones
  // so the engine also drains completely between beats
  task automatic offer(mste_cmd_e op, logic [ELEM_W-1:0] idx, logic [DATA_W-1:0] val,
                       logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 800) : $urandom_range(0, 30);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.cmd        <= op;
    cmd_if.elem_index <= idx;
    cmd_if.elem_value <= val;
    cmd_if.vert_x     <= x;
    cmd_if.vert_y     <= y;
    cmd_if.vert_z     <= z;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    burst_left--;
    sent++;
    if (op == CMD_PUSH && stack_est < STACK_DEPTH_DEF) stack_est++;
    if (op == CMD_POP && stack_est > 0) stack_est--;
  endtask

  // unused fields of each command carry random noise
  task automatic load_elem(logic [ELEM_W-1:0] idx, logic [DATA_W-1:0] val);
    offer(CMD_LOAD, idx, val, rnd48(), rnd48(), rnd48());
  endtask

  task automatic push_top();
    offer(CMD_PUSH, ELEM_W'($urandom), rnd48(), rnd48(), rnd48(), rnd48());
  endtask

  task automatic pop_top();
    offer(CMD_POP, ELEM_W'($urandom), rnd48(), rnd48(), rnd48(), rnd48());
  endtask

  task automatic xform(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
    offer(CMD_XFORM, ELEM_W'($urandom), rnd48(), x, y, z);
  endtask

  // result side: segments of steady, patchy or sparse acceptance, and every
  // so often a long hold-off so results back up and the engine stalls its
  // command side while the sender keeps a beat on offer
  initial begin : result_drain
    int unsigned seg;
    int unsigned span;
    int unsigned mode;
    res_if.ready <= 1'b0;
    seg = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      seg++;
      if (seg == 4 || seg % 200 == 0) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        span = $urandom_range(10, 300);
        mode = $urandom_range(0, 3);
        repeat (span) begin
          case (mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 1) == 1);
            2: res_if.ready <= ($urandom_range(0, 4) == 0);
            default: res_if.ready <= ($urandom_range(0, 9) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    cmd_if.valid      <= 1'b0;
    cmd_if.cmd        <= CMD_LOAD;
    cmd_if.elem_index <= '0;
    cmd_if.elem_value <= '0;
    cmd_if.vert_x     <= '0;
    cmd_if.vert_y     <= '0;
    cmd_if.vert_z     <= '0;
    sent       = 0;
    burst_left = 0;
    stack_est  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: pop and transform both report empty
    pop_top();
    xform(FIX_MAX, FIX_MIN, '1);
    // identity with a saturated x translation, copied onto the empty stack
    load_elem(0, FIX_ONE);
    load_elem(5, FIX_ONE);
    load_elem(10, FIX_ONE);
    load_elem(15, FIX_ONE);
    load_elem(3, FIX_MAX);
    push_top();
    xform(FIX_ONE, 2 * FIX_ONE, -(3 * FIX_ONE));
    xform(FIX_MIN, FIX_MAX, '0);
    // staging with a zero bottom row: the product's w row is all zero
    load_elem(3, -FIX_HALF);
    load_elem(15, '0);
    push_top();
    xform(FIX_ONE, FIX_ONE, FIX_ONE);
    pop_top();
    // w row of one lsb in x: a one-lsb vertex gives a w that rounds to zero
    load_elem(12, 48'd1);
    push_top();
    xform(48'd1, '0, '0);
    xform(FIX_MAX, '0, '0);
    // extreme elements to saturate the matrix product
    load_elem(15, FIX_MIN);
    load_elem(14, FIX_MAX);
    push_top();
    xform(FIX_ONE, -FIX_ONE, FIX_HALF);

    // fill the stack to the top and push past it
    while (stack_est < STACK_DEPTH_DEF) begin
      if ($urandom_range(0, 1) == 1) load_elem(ELEM_W'($urandom), pick_value());
      push_top();
    end
    push_top();
    xform(pick_value(), pick_value(), pick_value());

    // random scenarios built from well-formed command sequences
    while (sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // full affine-style matrix, bottom row mostly (0, 0, 0, 1)
        if (stack_est > 12 && $urandom_range(0, 1) == 1) pop_top();
        for (int i = 0; i < 16; i++) begin
          if (i < 12 || $urandom_range(0, 4) == 0) load_elem(ELEM_W'(i), pick_value());
          else load_elem(ELEM_W'(i), (i == 15) ? FIX_ONE : '0);
        end
        push_top();
      end else if (pick < 45) begin
        // touch up a few staging elements, then push
        n = $urandom_range(1, 4);
        repeat (n) load_elem(ELEM_W'($urandom), pick_value());
        push_top();
      end else if (pick < 75) begin
        n = $urandom_range(1, 6);
        repeat (n) xform(pick_value(), pick_value(), pick_value());
      end else if (pick < 85) begin
        n = $urandom_range(1, 3);
        repeat (n) pop_top();
        xform(pick_value(), pick_value(), pick_value());
      end else if (pick < 90) begin
        // deep run of pushes, often reaching a full stack
        n = $urandom_range(4, 16);
        repeat (n) push_top();
      end else begin
        offer(mste_cmd_e'($urandom_range(0, 3)), ELEM_W'($urandom), rnd48(), rnd48(),
              rnd48(), rnd48());
      end
    end
    cmd_if.valid <= 1'b0;

    // wait for the last results, then a short quiet window for stray beats
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
